// ----- sv/signed_integer_text_parser_top_defines.svh -----
// Assertion macros shared by the parser RTL.
`ifndef SIGNED_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH
`define SIGNED_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SITP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sitp_pkg.sv -----
package sitp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int CHAR_WIDTH      = 8;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;
    localparam logic [2:0] PH_DEC  = 3'd5;
    localparam logic [2:0] PH_STOP = 3'd6;

    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [2:0] phase;
        logic       minus_seen;
    } parse_ctrl_t;

endpackage

// ----- sv/sitp_step.sv -----
module sitp_step #(
    parameter int VALUE_WIDTH = sitp_pkg::VALUE_WIDTH_DEF
) (
    input  sitp_pkg::parse_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0]             acc,
    input  logic [sitp_pkg::CHAR_WIDTH-1:0]    char_code,
    output sitp_pkg::parse_ctrl_t              ctrl_next,
    output logic [VALUE_WIDTH-1:0]             acc_next
);
    import sitp_pkg::*;

    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    logic                   is_blank;
    logic                   is_dec;
    logic                   is_oct;
    logic                   is_hex;
    logic                   take_digit;
    logic [1:0]             base_sel;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] scaled;

    assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
    assign is_dec   = char_code inside {[CH_0:CH_9]};
    assign is_oct   = char_code inside {[CH_0:CH_7]};
    assign is_hex   = char_code inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
    assign digit    = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;

    always_comb
    begin
        ctrl_next  = ctrl;
        take_digit = 1'b0;
        base_sel   = BASE_DEC;
        case (ctrl.phase)
            PH_LEAD, PH_SIGN:
            begin
                if (is_blank)
                begin
                    ctrl_next = ctrl;
                end
                else if ((ctrl.phase == PH_LEAD) &&
                         ((char_code == CH_MINUS) || (char_code == CH_PLUS)))
                begin
                    ctrl_next.minus_seen = (char_code == CH_MINUS);
                    ctrl_next.phase      = PH_SIGN;
                end
                else if (char_code == CH_0)
                begin
                    ctrl_next.phase = PH_ZERO;
                end
                else if (is_dec)
                begin
                    take_digit      = 1'b1;
                    ctrl_next.phase = PH_DEC;
                end
                else
                begin
                    ctrl_next.phase = PH_STOP;
                end
            end
            PH_ZERO:
            begin
                if ((char_code == CH_LX) || (char_code == CH_UX))
                begin
                    ctrl_next.phase = PH_HEX;
                end
                else if (is_oct)
                begin
                    take_digit      = 1'b1;
                    base_sel        = BASE_OCT;
                    ctrl_next.phase = PH_OCT;
                end
                else
                begin
                    ctrl_next.phase = PH_STOP;
                end
            end
            PH_HEX:
            begin
                base_sel = BASE_HEX;
                if (is_hex)
                begin
                    take_digit = 1'b1;
                end
                else
                begin
                    ctrl_next.phase = PH_STOP;
                end
            end
            PH_OCT:
            begin
                base_sel = BASE_OCT;
                if (is_oct)
                begin
                    take_digit = 1'b1;
                end
                else
                begin
                    ctrl_next.phase = PH_STOP;
                end
            end
            PH_DEC:
            begin
                if (is_dec)
                begin
                    take_digit = 1'b1;
                end
                else
                begin
                    ctrl_next.phase = PH_STOP;
                end
            end
            default:
            begin
                ctrl_next = ctrl;
            end
        endcase
    end

    always_comb
    begin
        case (base_sel)
            BASE_OCT: scaled = acc << 3;
            BASE_HEX: scaled = acc << 4;
            default:  scaled = (acc << 3) + (acc << 1);
        endcase
    end

    assign acc_next = take_digit ? scaled + {{(VALUE_WIDTH-4){1'b0}}, digit} : acc;

endmodule

// ----- sv/signed_integer_text_parser_top.sv -----
// Signed integer text parser with automatic base detection.
// The slave channel carries one ASCII character per transaction in
// s_axis_tdata, and s_axis_tlast marks the final character of a string.
// Blanks, an optional sign, a 0x or 0 prefix and the digits are parsed as
// they arrive; the first character that does not fit ends the number.
// Each string yields one master transaction when its last character has
// been parsed: the signed value, wrapped to VALUE_WIDTH bits and fitted to
// the 32-bit m_axis_tdata.
// One character is accepted per cycle. A character is held in the input
// register and then parsed into the parse state; a last character is
// parsed into the result register instead, which raises m_axis_tvalid.
// A stalled receiver holds the result; characters that end no string keep
// flowing, and a last character waits only while the result register is
// still full and not being taken.
// Reset clears the parse state and both valid flags; the block is ready
// as soon as reset is released.
`include "signed_integer_text_parser_top_defines.svh"

module signed_integer_text_parser_top #(
    parameter int VALUE_WIDTH = sitp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sitp_pkg::CHAR_WIDTH-1:0]   s_axis_tdata,  // char_code
    input  logic                              s_axis_tlast,  // last_char
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sitp_pkg::OUT_WIDTH-1:0]    m_axis_tdata   // value
);
    import sitp_pkg::*;

    logic                     in_valid_reg;
    logic [CHAR_WIDTH-1:0]    in_char_reg;
    logic                     in_last_reg;
    parse_ctrl_t              ctrl_reg;
    parse_ctrl_t              ctrl_next;
    logic [VALUE_WIDTH-1:0]   acc_reg;
    logic [VALUE_WIDTH-1:0]   acc_next;
    logic                     out_valid_reg;
    logic [OUT_WIDTH-1:0]     out_value_reg;

    logic                     out_free;
    logic                     in_move;
    logic [VALUE_WIDTH-1:0]   signed_value;
    logic [VALUE_WIDTH+OUT_WIDTH-1:0] value_ext;

    sitp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .ctrl      (ctrl_reg),
        .acc       (acc_reg),
        .char_code (in_char_reg),
        .ctrl_next (ctrl_next),
        .acc_next  (acc_next)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_move       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || in_move;

    assign signed_value = ctrl_next.minus_seen ? ('0 - acc_next) : acc_next;
    assign value_ext    = {{OUT_WIDTH{1'b0}}, signed_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '{phase: PH_LEAD, minus_seen: 1'b0};
            acc_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (in_move && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_move)
            begin
                if (in_last_reg)
                begin
                    ctrl_reg <= '{phase: PH_LEAD, minus_seen: 1'b0};
                    acc_reg  <= '0;
                end
                else
                begin
                    ctrl_reg <= ctrl_next;
                    acc_reg  <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (in_move && in_last_reg)
        begin
            out_value_reg <= value_ext[OUT_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;

    `SITP_ASSERT_NEXT(a_result_follows_last, in_move && in_last_reg, m_axis_tvalid,
        "no result after last character")
    `SITP_ASSERT_NEXT(a_restart_after_last, in_move && in_last_reg,
        (acc_reg == '0) && (ctrl_reg.phase == PH_LEAD) && !ctrl_reg.minus_seen,
        "parse state not cleared after last character")
    `SITP_ASSERT_NOW(a_stall_only_on_full_output, in_valid_reg && !s_axis_tready,
        in_last_reg && out_valid_reg && !m_axis_tready, "input stalled without a blocked result")
    `SITP_ASSERT_NEXT(a_idle_state_holds, !in_move, $stable(acc_reg) && $stable(ctrl_reg),
        "parse state changed without a character")

endmodule

// ----- test/sitp_checker.sv -----
`timescale 1ns / 1ps

module sitp_checker
    import sitp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [CHAR_WIDTH-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_WIDTH-1:0]  m_axis_tdata,
    output int                    error_count,
    output int                    pending_count,
    output int                    chars_seen,
    output int                    values_seen
);

    logic [2:0]           scan_phase = PH_LEAD;
    logic                 negative   = 1'b0;
    logic [31:0]          acc        = '0;
    logic [OUT_WIDTH-1:0] expected_values[$];
    logic [OUT_WIDTH-1:0] want;
    int                   mismatches = 0;
    int                   char_total = 0;
    int                   value_total = 0;

    function automatic bit is_blank(input logic [CHAR_WIDTH-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    task automatic push_digit(input logic [31:0] radix, input logic [CHAR_WIDTH-1:0] digit);
        acc = acc * radix + 32'(digit);
    endtask

    task automatic start_number(input logic [CHAR_WIDTH-1:0] c);
        if (c == CH_0)
        begin
            scan_phase = PH_ZERO;
        end
        else if (c > CH_0 && c <= CH_9)
        begin
            push_digit(32'd10, c - CH_0);
            scan_phase = PH_DEC;
        end
        else
        begin
            scan_phase = PH_STOP;
        end
    endtask

    task automatic parse_char(input logic [CHAR_WIDTH-1:0] c);
        case (scan_phase)
            PH_LEAD:
            begin
                if (c == CH_MINUS || c == CH_PLUS)
                begin
                    negative   = (c == CH_MINUS);
                    scan_phase = PH_SIGN;
                end
                else if (!is_blank(c))
                begin
                    start_number(c);
                end
            end
            PH_SIGN:
            begin
                if (!is_blank(c))
                begin
                    start_number(c);
                end
            end
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    scan_phase = PH_HEX;
                end
                else if (c >= CH_0 && c <= CH_7)
                begin
                    push_digit(32'd8, c - CH_0);
                    scan_phase = PH_OCT;
                end
                else
                begin
                    scan_phase = PH_STOP;
                end
            end
            PH_HEX:
            begin
                if (c >= CH_0 && c <= CH_9)
                begin
                    push_digit(32'd16, c - CH_0);
                end
                else if (c >= CH_LA && c <= CH_LF)
                begin
                    push_digit(32'd16, c - CH_LA + 8'd10);
                end
                else if (c >= CH_UA && c <= CH_UF)
                begin
                    push_digit(32'd16, c - CH_UA + 8'd10);
                end
                else
                begin
                    scan_phase = PH_STOP;
                end
            end
            PH_OCT:
            begin
                if (c >= CH_0 && c <= CH_7)
                begin
                    push_digit(32'd8, c - CH_0);
                end
                else
                begin
                    scan_phase = PH_STOP;
                end
            end
            PH_DEC:
            begin
                if (c >= CH_0 && c <= CH_9)
                begin
                    push_digit(32'd10, c - CH_0);
                end
                else
                begin
                    scan_phase = PH_STOP;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase = PH_LEAD;
            negative   = 1'b0;
            acc        = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                char_total++;
                parse_char(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    expected_values.push_back(negative ? 32'd0 - acc : acc);
                    scan_phase = PH_LEAD;
                    negative   = 1'b0;
                    acc        = '0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                value_total++;
                if (expected_values.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("Unexpected value %0d (0x%08h) at %0t",
                                 $signed(m_axis_tdata), m_axis_tdata, $realtime);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("Value mismatch at %0t: expected %0d (0x%08h), got %0d (0x%08h)",
                                     $realtime, $signed(want), want,
                                     $signed(m_axis_tdata), m_axis_tdata);
                        end
                        mismatches++;
                    end
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_values.size();
        chars_seen    <= char_total;
        values_seen   <= value_total;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sitp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHARS = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CHAR_WIDTH-1:0] s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_WIDTH-1:0]  m_axis_tdata;

    int error_count;
    int pending_count;
    int chars_seen;
    int values_seen;

    int idle_pct  = 0;
    int stall_pct = 0;
    logic hold_rx    = 1'b0;
    logic hold_start = 1'b0;
    int cycle_count  = 0;
    int chars_sent   = 0;
    logic [CHAR_WIDTH-1:0] word_chars[$];

    string digit_set = "0123456789abcdefABCDEF";
    string odd_set   = "+- \t0xX79aAfFgG";

    signed_integer_text_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sitp_checker u_value_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .chars_seen    (chars_seen),
        .values_seen   (values_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d values still expected",
                     cycle_count, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        wait (hold_start);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_char(input logic [CHAR_WIDTH-1:0] code, input logic is_last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_word(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_char(text[i], i == text.len() - 1);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < word_chars.size(); i++)
        begin
            send_char(word_chars[i], i == word_chars.size() - 1);
        end
    endtask

    // Mostly well-formed numbers with random blanks, sign, base, length and
    // trailing junk; the rest is short runs of arbitrary bytes.
    task automatic build_number_text();
        int radix_pick;
        int digit_count;
        word_chars.delete();
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(1))
                    word_chars.push_back(8'($urandom_range(255)));
                else
                    word_chars.push_back(odd_set[$urandom_range(odd_set.len() - 1)]);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                word_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(2))
                1: word_chars.push_back(CH_PLUS);
                2: word_chars.push_back(CH_MINUS);
                default: ;
            endcase
            if (word_chars.size() > 0 && $urandom_range(3) == 0)
                word_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            radix_pick  = $urandom_range(2);
            digit_count = ($urandom_range(99) < 85) ? $urandom_range(0, 8)
                                                    : $urandom_range(9, 14);
            if (radix_pick == 0)
            begin
                if (digit_count > 0)
                    word_chars.push_back(8'(CH_0 + $urandom_range(1, 9)));
                repeat (digit_count > 0 ? digit_count - 1 : 0)
                    word_chars.push_back(8'(CH_0 + $urandom_range(9)));
            end
            else if (radix_pick == 1)
            begin
                word_chars.push_back(CH_0);
                repeat (digit_count)
                    word_chars.push_back(8'(CH_0 + $urandom_range(7)));
            end
            else
            begin
                word_chars.push_back(CH_0);
                word_chars.push_back($urandom_range(1) ? CH_LX : CH_UX);
                repeat (digit_count)
                    word_chars.push_back(digit_set[$urandom_range(digit_set.len() - 1)]);
            end
            repeat ($urandom_range(0, 2))
                word_chars.push_back(8'($urandom_range(255)));
        end
        if (word_chars.size() == 0)
            word_chars.push_back(CH_SPACE);
    endtask

    initial
    begin
        int start_count;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word("0");
        send_word("0x");
        send_word("08");
        send_word("+-5");
        send_char(8'h00, 1'b0);
        send_char(CH_0 + 8'd5, 1'b1);
        send_word("-0X80000000");
        send_word("\t017");
        send_char(CH_9, 1'b0);
        send_char(8'hFF, 1'b1);
        send_word(" ");

        start_count = chars_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (phase == 0)
                hold_start = 1'b1;
            while (chars_sent < start_count + (phase + 1) * RANDOM_CHARS / 4)
            begin
                build_number_text();
                send_buffer();
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Parsed %0d characters into %0d checked values, with idle and stall phases",
                 chars_seen, values_seen);
        $display("and one long receiver hold-off; %0d mismatches", error_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
